>>> rtl/fem_pkg.sv
// Shared types and constants for the file extent map lookup block.
// No dependencies; fem_front, fem_back and the top level import this package.
`default_nettype none

package fem_pkg;

   localparam int MAX_EXTENTS_DEF = 64;
   localparam int BLOCK_SHIFT_DEF = 12;

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef enum logic [1:0] {
      CMD_ADD,
      CMD_LOOKUP,
      CMD_MISS
   } cmd_kind_type;

   typedef struct packed {
      logic        op;
      logic [62:0] extent_byte_offset;
      logic [63:0] extent_phys_block;
      logic [55:0] extent_byte_length;
      logic [62:0] lookup_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] phys_block;
      logic [43:0] extent_blocks;
      logic [11:0] offset_in_block;
   } rsp_type;

   // Classified command. For an add, blk is the logical start block, base is
   // the physical start minus the logical start and blk_end is one past the
   // last block. For a lookup, blk is the block number of the offset.
   typedef struct packed {
      cmd_kind_type kind;
      logic [62:0]  blk;
      logic [63:0]  base;
      logic [63:0]  blk_end;
      logic [43:0]  count;
      logic [11:0]  obo;
   } cmd_type;

endpackage

`default_nettype wire

>>> rtl/fem_fifo.sv
// Two-entry queue of fixed-width beats.
// Depends on nothing; used for the command queue and the result queue.
`default_nettype none

module fem_fifo #(
   parameter int WIDTH = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam logic [1:0] DEPTH = 2'd2;

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == DEPTH);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/fem_front.sv
// Front end: holds the file size register, classifies request beats into
// commands and queues them. Depends on fem_pkg and fem_fifo.
`default_nettype none

module fem_front
   import fem_pkg::*;
#(
   parameter int BLOCK_SHIFT = BLOCK_SHIFT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire req_type     req_data,
   output logic             full,
   input  wire logic        csr_wr_en,
   input  wire logic [62:0] csr_wr_data,
   input  wire logic        cmd_pop,
   output cmd_type          cmd_data,
   output logic             cmd_empty
);

   localparam logic [11:0] OBO_MASK = 12'((64'd1 << BLOCK_SHIFT) - 64'd1);

   logic [62:0] file_size_ff, file_size_in;
   cmd_type     cmd_in;
   logic [62:0] add_blk;
   logic [62:0] look_blk;
   logic [43:0] add_count;

   assign file_size_in = csr_wr_en ? csr_wr_data : file_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         file_size_ff <= 63'd0;
      end else begin
         file_size_ff <= file_size_in;
      end
   end

   always_comb begin
      add_blk   = req_data.extent_byte_offset >> BLOCK_SHIFT;
      look_blk  = req_data.lookup_offset >> BLOCK_SHIFT;
      add_count = 44'(req_data.extent_byte_length >> BLOCK_SHIFT);

      cmd_in.base    = req_data.extent_phys_block - {1'b0, add_blk};
      cmd_in.blk_end = {1'b0, add_blk} + {20'd0, add_count};
      cmd_in.count   = add_count;
      cmd_in.obo     = req_data.lookup_offset[11:0] & OBO_MASK;
      if (req_data.op == OP_ADD) begin
         cmd_in.kind = CMD_ADD;
         cmd_in.blk  = add_blk;
      end else begin
         cmd_in.kind = (req_data.lookup_offset >= file_size_ff) ? CMD_MISS : CMD_LOOKUP;
         cmd_in.blk  = look_blk;
      end
   end

   fem_fifo #(
      .WIDTH ($bits(cmd_type))
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (cmd_in),
      .full      (full),
      .pop       (cmd_pop),
      .pop_data  (cmd_data),
      .empty     (cmd_empty)
   );

endmodule

`default_nettype wire

>>> rtl/fem_back.sv
// Back end: extent table memory, append on add, in-order scan on lookup.
// Depends on fem_pkg; feeds the result queue at the top level.
`default_nettype none

module fem_back
   import fem_pkg::*;
#(
   parameter int MAX_EXTENTS = MAX_EXTENTS_DEF,
   parameter int BLOCK_SHIFT = BLOCK_SHIFT_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd_data,
   input  wire logic    cmd_empty,
   output logic         cmd_pop,
   input  wire logic    rsp_full,
   output logic         rsp_push,
   output rsp_type      rsp_beat
);

   localparam int LBW = 63 - BLOCK_SHIFT;
   localparam int EW  = ((LBW > 44) ? LBW : 44) + 1;
   localparam int AW  = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
   localparam int UW  = $clog2(MAX_EXTENTS + 1);
   localparam logic [UW-1:0] USED_MAX = UW'(MAX_EXTENTS);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // extent table; base holds physical start minus logical start
   logic [LBW-1:0] lb_mem   [MAX_EXTENTS];
   logic [63:0]    base_mem [MAX_EXTENTS];
   logic [EW-1:0]  end_mem  [MAX_EXTENTS];
   logic [43:0]    cnt_mem  [MAX_EXTENTS];

   logic [LBW-1:0] rd_lb_ff;
   logic [63:0]    rd_base_ff;
   logic [EW-1:0]  rd_end_ff;
   logic [43:0]    rd_cnt_ff;

   state_type      state_ff, state_in;
   logic [UW-1:0]  used_ff, used_in;
   logic [UW-1:0]  cmp_idx_ff, cmp_idx_in;
   logic [62:0]    cur_blk_ff, cur_blk_in;
   logic [11:0]    cur_obo_ff, cur_obo_in;
   logic [UW-1:0]  cmp_next;
   logic [AW-1:0]  rd_addr;
   logic           mem_we;
   logic           hit;

   assign cmp_next = cmp_idx_ff + UW'(1);
   assign hit = ({1'b0, cur_blk_ff} >= 64'(rd_lb_ff)) &&
                ({1'b0, cur_blk_ff} < 64'(rd_end_ff));

   always_comb begin
      state_in   = state_ff;
      used_in    = used_ff;
      cmp_idx_in = cmp_idx_ff;
      cur_blk_in = cur_blk_ff;
      cur_obo_in = cur_obo_ff;
      cmd_pop    = 1'b0;
      rsp_push   = 1'b0;
      rsp_beat   = '0;
      mem_we     = 1'b0;
      rd_addr    = '0;
      case (state_ff)
         ST_IDLE: begin
            // one command in flight, so a free result slot stays free
            if (!cmd_empty && !rsp_full) begin
               cmd_pop = 1'b1;
               case (cmd_data.kind)
                  CMD_ADD: begin
                     rsp_push = 1'b1;
                     if (used_ff == USED_MAX) begin
                        rsp_beat.status = STATUS_FULL;
                     end else begin
                        rsp_beat.status = STATUS_OK;
                        mem_we  = 1'b1;
                        used_in = used_ff + UW'(1);
                     end
                  end
                  CMD_LOOKUP: begin
                     if (used_ff == '0) begin
                        rsp_push        = 1'b1;
                        rsp_beat.status = STATUS_MISS;
                     end else begin
                        rd_addr    = '0;
                        cmp_idx_in = '0;
                        cur_blk_in = cmd_data.blk;
                        cur_obo_in = cmd_data.obo;
                        state_in   = ST_SCAN;
                     end
                  end
                  default: begin
                     rsp_push        = 1'b1;
                     rsp_beat.status = STATUS_MISS;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (hit) begin
               rsp_push                 = 1'b1;
               rsp_beat.status          = STATUS_OK;
               rsp_beat.phys_block      = rd_base_ff + {1'b0, cur_blk_ff};
               rsp_beat.extent_blocks   = rd_cnt_ff;
               rsp_beat.offset_in_block = cur_obo_ff;
               state_in                 = ST_IDLE;
            end else if (cmp_next == used_ff) begin
               rsp_push        = 1'b1;
               rsp_beat.status = STATUS_MISS;
               state_in        = ST_IDLE;
            end else begin
               rd_addr    = cmp_next[AW-1:0];
               cmp_idx_in = cmp_next;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         used_ff    <= '0;
         cmp_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         used_ff    <= used_in;
         cmp_idx_ff <= cmp_idx_in;
      end
      cur_blk_ff <= cur_blk_in;
      cur_obo_ff <= cur_obo_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         lb_mem[used_ff[AW-1:0]]   <= cmd_data.blk[LBW-1:0];
         base_mem[used_ff[AW-1:0]] <= cmd_data.base;
         end_mem[used_ff[AW-1:0]]  <= cmd_data.blk_end[EW-1:0];
         cnt_mem[used_ff[AW-1:0]]  <= cmd_data.count;
      end
      rd_lb_ff   <= lb_mem[rd_addr];
      rd_base_ff <= base_mem[rd_addr];
      rd_end_ff  <= end_mem[rd_addr];
      rd_cnt_ff  <= cnt_mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/file_extent_map_lookup_top.sv
// File extent map lookup, top level: front end, back end and result queue.
// Depends on fem_pkg, fem_fifo, fem_front and fem_back.
//
// Requests enter on req_data when push is high and full is low; op selects
// add extent or look up a byte offset. Results leave on rsp_data while empty
// is low and are taken when pop is high. Every request yields exactly one
// result, in request order. The user must write the file size register via
// csr_wr_en / csr_wr_data only while the block is idle; it is not enforced.
//
// A two-beat command queue parts the front end from the back end, and a
// two-beat result queue parts the back end from the receiver, so requests
// keep being taken while a result waits. An add or an early miss is
// answered as soon as the back end pops it. A lookup scans the table one
// entry per cycle through the memory read port, oldest extent first, and
// ends at the first hit or after the last of the stored extents; the back
// end takes no other command while it scans. When the result queue fills,
// the back end holds, then the command queue fills and full rises.
// Reset empties both queues and the table and clears the file size to 0.
`default_nettype none

module file_extent_map_lookup_top
   import fem_pkg::*;
#(
   parameter int MAX_EXTENTS = MAX_EXTENTS_DEF,
   parameter int BLOCK_SHIFT = BLOCK_SHIFT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire req_type     req_data,
   output logic             full,
   output logic             empty,
   input  wire logic        pop,
   output rsp_type          rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [62:0] csr_wr_data
);

   cmd_type cmd_data;
   logic    cmd_empty;
   logic    cmd_pop;
   logic    rsp_full;
   logic    rsp_push;
   rsp_type rsp_beat;

   fem_front #(
      .BLOCK_SHIFT (BLOCK_SHIFT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .req_data    (req_data),
      .full        (full),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_pop     (cmd_pop),
      .cmd_data    (cmd_data),
      .cmd_empty   (cmd_empty)
   );

   fem_back #(
      .MAX_EXTENTS (MAX_EXTENTS),
      .BLOCK_SHIFT (BLOCK_SHIFT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (cmd_data),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_beat  (rsp_beat)
   );

   fem_fifo #(
      .WIDTH ($bits(rsp_type))
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_beat),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty)
   );

   a_cmd_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("back end popped an empty command queue");

   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result beat pushed into a full result queue");

   a_req_reaches_queue: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> !cmd_empty)
      else $error("accepted request missing from command queue");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for file_extent_map_lookup_top: directed and random extent adds and
// lookups, each result beat checked against an in-bench copy of the extent table.
// Depends on fem_pkg and the rtl of the block.

module tb_top
   import fem_pkg::*;
();

   localparam int MAX_EXT = MAX_EXTENTS_DEF;
   localparam int BS = BLOCK_SHIFT_DEF;
   localparam int LBW = 63 - BS;
   localparam logic [63:0] BLK = 64'd1 << BS;
   localparam logic [62:0] SIZE_MAX = {63{1'b1}};
   localparam int STUCK_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;

   logic clock;
   logic reset;
   logic push;
   logic full;
   logic empty;
   logic pop;
   logic csr_wr_en;
   logic [62:0] csr_wr_data;
   req_type req_data;
   rsp_type rsp_data;

   // bench copy of the extent table and the file size register
   logic [62-BS:0] tbl_lblk [MAX_EXT];
   logic [63:0] tbl_pblk [MAX_EXT];
   logic [43:0] tbl_cnt [MAX_EXT];
   int tbl_used;
   logic [62:0] fsize;

   rsp_type answers_due[$];
   int bad_fields;
   int stuck_cycles;
   bit steady;
   bit rsp_hold_req;

   file_extent_map_lookup_top uut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .req_data(req_data),
      .full(full),
      .empty(empty),
      .pop(pop),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #4 clock = ~clock;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Updates the table on an add and answers the item.
   function automatic rsp_type extent_map_answer(req_type r);
      rsp_type a;
      logic [63:0] bno;
      logic [63:0] lb;
      logic [63:0] lim;
      bit hit;
      a = '0;
      hit = 1'b0;
      if (r.op == OP_ADD) begin
         if (tbl_used >= MAX_EXT) begin
            a.status = STATUS_FULL;
         end else begin
            tbl_lblk[tbl_used] = LBW'(r.extent_byte_offset >> BS);
            tbl_pblk[tbl_used] = r.extent_phys_block;
            tbl_cnt[tbl_used] = 44'(r.extent_byte_length >> BS);
            tbl_used++;
            a.status = STATUS_OK;
         end
      end else if (r.lookup_offset >= fsize) begin
         a.status = STATUS_MISS;
      end else begin
         a.status = STATUS_MISS;
         bno = 64'(r.lookup_offset >> BS);
         // earliest added entry wins on overlap; empty extents never match
         for (int i = 0; i < tbl_used; i++) begin
            lb = 64'(tbl_lblk[i]);
            lim = lb + 64'(tbl_cnt[i]);
            if (!hit && bno >= lb && bno < lim) begin
               hit = 1'b1;
               a.status = STATUS_OK;
               a.phys_block = tbl_pblk[i] + (bno - lb);
               a.extent_blocks = tbl_cnt[i];
               a.offset_in_block = 12'(r.lookup_offset & ((63'd1 << BS) - 63'd1));
            end
         end
      end
      return a;
   endfunction

   function automatic req_type add_req(logic [62:0] off, logic [55:0] len,
                                       logic [63:0] phys);
      req_type r;
      r.op = OP_ADD;
      r.extent_byte_offset = off;
      r.extent_phys_block = phys;
      r.extent_byte_length = len;
      r.lookup_offset = 63'(rand64());
      return r;
   endfunction

   function automatic req_type lookup_req(logic [62:0] off);
      req_type r;
      r.op = OP_LOOKUP;
      r.extent_byte_offset = 63'(rand64());
      r.extent_phys_block = rand64();
      r.extent_byte_length = 56'(rand64());
      r.lookup_offset = off;
      return r;
   endfunction

   // Mostly small extents in a shared region so lookups overlap and hit;
   // lookups mostly aim at stored extents and their edges.
   function automatic req_type random_item(int add_pct);
      logic [63:0] lb;
      logic [63:0] cnt;
      logic [63:0] off;
      int sel;
      int i;
      if ($urandom_range(0, 99) < add_pct) begin
         if ($urandom_range(0, 7) == 0)
            return add_req(63'(rand64()), 56'(rand64()), rand64());
         lb = 64'($urandom_range(0, 2047));
         cnt = ($urandom_range(0, 11) == 0) ? 64'd0 : 64'($urandom_range(1, 63));
         return add_req(63'((lb << BS) + $urandom_range(0, BLK - 1)),
                        56'((cnt << BS) + $urandom_range(0, BLK - 1)), rand64());
      end
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
         off = rand64();
      end else if (sel < 30 || tbl_used == 0) begin
         off = (64'($urandom_range(0, 2100)) << BS) + $urandom_range(0, BLK - 1);
      end else begin
         i = $urandom_range(0, tbl_used - 1);
         lb = 64'(tbl_lblk[i]);
         cnt = 64'(tbl_cnt[i]);
         case ($urandom_range(0, 9))
            0: off = (lb << BS) - 64'd1;
            1: off = (lb + cnt) << BS;
            2: off = ((lb + cnt) << BS) - 64'd1;
            default: begin
               off = ((lb + ((cnt == 0) ? 64'd0 : rand64() % cnt)) << BS)
                     + $urandom_range(0, BLK - 1);
            end
         endcase
      end
      return lookup_req(63'(off));
   endfunction

   task automatic send_item(input req_type r);
      while (!steady && $urandom_range(0, 99) < 10) begin
         push <= 1'b0;
         @(posedge clock);
      end
      req_data <= r;
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      answers_due = {answers_due, extent_map_answer(r)};
   endtask

   // Every item answers once, so an empty queue means the block is idle.
   task automatic settle();
      push <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_file_size(input logic [62:0] v);
      settle();
      csr_wr_data <= v;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      fsize = v;
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         bad_fields++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (answers_due.size() == 0) begin
            $error("result beat with nothing pending, status %0d", rsp_data.status);
            bad_fields++;
         end else begin
            want = answers_due.pop_front();
            check_field("status", 64'(want.status), 64'(rsp_data.status));
            check_field("phys_block", want.phys_block, rsp_data.phys_block);
            check_field("extent_blocks", 64'(want.extent_blocks),
                        64'(rsp_data.extent_blocks));
            check_field("offset_in_block", 64'(want.offset_in_block),
                        64'(rsp_data.offset_in_block));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // result side: random pop gaps, one long hold-off on request
   initial begin
      int hold_left;
      bit held;
      hold_left = 0;
      held = 1'b0;
      pop = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req && !held) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else if (!steady && $urandom_range(0, 99) < 10) begin
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   task automatic test_empty_table();
      // file size is zero out of reset: everything misses
      send_item(lookup_req('0));
      send_item(lookup_req(SIZE_MAX));
      write_file_size(SIZE_MAX);
      send_item(lookup_req('0));
      send_item(lookup_req(63'(rand64())));
   endtask

   task automatic test_extent_cases();
      send_item(add_req(63'h123, 56'(3 * BLK + 7), 64'd100));
      send_item(add_req(63'(10 * BLK), 56'(BLK - 1), 64'd5));   // under one block
      send_item(add_req(63'(2 * BLK), 56'(8 * BLK), 64'd1000)); // overlaps the first
      send_item(add_req(63'd1 << 40, 56'(16 * BLK), 64'hFFFF_FFFF_FFFF_FFFC));
      send_item(add_req(SIZE_MAX, {56{1'b1}}, {64{1'b1}}));
      send_item(lookup_req('0));
      send_item(lookup_req(63'(3 * BLK - 1)));
      send_item(lookup_req(63'(3 * BLK)));
      send_item(lookup_req(63'(10 * BLK)));
      send_item(lookup_req(63'(10 * BLK - 1)));
      send_item(lookup_req((63'd1 << 40) + 63'(5 * BLK + 9)));  // phys wraps
      send_item(lookup_req(SIZE_MAX - 63'd1));
      send_item(lookup_req(SIZE_MAX));
   endtask

   task automatic test_size_boundary();
      write_file_size(63'(5 * BLK + 1));
      send_item(lookup_req(63'(5 * BLK)));
      send_item(lookup_req(63'(5 * BLK + 1)));
   endtask

   task automatic test_random_traffic();
      write_file_size(SIZE_MAX);
      repeat (250) send_item(random_item(5));
      write_file_size(63'(rand64()));
      steady = 1'b1;
      repeat (250) send_item(random_item(5));
      steady = 1'b0;
      write_file_size('0);
      repeat (40) send_item(random_item(5));
      write_file_size(SIZE_MAX - 63'($urandom_range(0, 8191)));
      repeat (220) send_item(random_item(5));
   endtask

   task automatic test_backpressure();
      write_file_size(63'((64'($urandom_range(1, 2048)) << BS) + $urandom_range(0, BLK - 1)));
      for (int n = 0; n < 260; n++) begin
         if (n == 40)
            rsp_hold_req = 1'b1;
         send_item(random_item(5));
      end
   endtask

   task automatic test_table_full();
      write_file_size(SIZE_MAX);
      while (tbl_used < MAX_EXT) send_item(random_item(100));
      repeat (3) send_item(random_item(100));
      repeat (8) send_item(random_item(0));
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      push = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      fsize = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_extent_cases();
      test_size_boundary();
      test_random_traffic();
      test_backpressure();
      test_table_full();
      settle();
      repeat (MAX_EXT + 8) @(posedge clock);
      if (bad_fields == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
